// ----- rtl/cpu_clock_frequency_meter_macros.svh -----
// Assertion macros shared by the checker of the clock frequency meter.
`ifndef CPU_CLOCK_FREQUENCY_METER_MACROS_SVH
`define CPU_CLOCK_FREQUENCY_METER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cfm_pkg.sv -----
// Shared constants, types and codes of the clock frequency meter.
package cfm_pkg;

	localparam int FIELD_W = 32;
	localparam int TICK_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DEF_TIME_WIDTH = 32;
	localparam int DEF_CYCLE_WIDTH = 32;

	localparam logic [FIELD_W-1:0] REF_FREQ_RESET = 32'd32768;
	localparam logic [TICK_W-1:0] TICK_COUNT_RESET = 16'd10;

	localparam logic [CFG_IDX_W-1:0] REG_REF_FREQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_COUNT = 2'd1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_WAIT_EDGE = 6'b000010,
		S_MEASURE = 6'b000100,
		S_DIV = 6'b001000,
		S_FRAC = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	typedef struct packed {
		logic capture_first;
		logic capture_edge;
		logic load_div;
		logic div_step;
		logic frac_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic ref_changed;
		logic window_done;
		logic step_last;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/cpu_clock_frequency_meter.sv -----
// Top level of the clock frequency meter: controller, datapath and configuration port.
// Samples that do not end a window are taken back to back.
// A sample that ends a window stalls the input until its result beat is loaded: CYCLE_WIDTH
// steps of the restoring divider, then two steps per reference frequency bit of the shared
// subtract unit, then the load of the result once the result register is free.
// Reset clears the state machine and the result valid and loads the registers' reset values.
module cpu_clock_frequency_meter #(
	parameter int TIME_WIDTH = cfm_pkg::DEF_TIME_WIDTH,
	parameter int CYCLE_WIDTH = cfm_pkg::DEF_CYCLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic start_req,
	input  logic [cfm_pkg::FIELD_W-1:0] ref_time,
	input  logic [cfm_pkg::FIELD_W-1:0] cycle_count,
	output logic out_valid,
	input  logic out_stall,
	output logic [cfm_pkg::FIELD_W-1:0] cpu_freq_hz,
	output logic saturated,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cfm_pkg::FIELD_W-1:0] cfg_data
);

	cfm_pkg::cmd_t cmd;
	cfm_pkg::status_t status;

	assign cfg_ready = 1'b1;

	cfm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.start_req(start_req),
		.status(status),
		.cmd(cmd),
		.in_stall(in_stall)
	);

	cfm_dp #(
		.TIME_WIDTH(TIME_WIDTH),
		.CYCLE_WIDTH(CYCLE_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.ref_time(ref_time),
		.cycle_count(cycle_count),
		.cfg_wr(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.cpu_freq_hz(cpu_freq_hz),
		.saturated(saturated)
	);

endmodule

// ----- rtl/cfm_dp.sv -----
// Datapath of the clock frequency meter: counter captures, divider, scaling and result register.
module cfm_dp #(
	parameter int TIME_WIDTH = cfm_pkg::DEF_TIME_WIDTH,
	parameter int CYCLE_WIDTH = cfm_pkg::DEF_CYCLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  cfm_pkg::cmd_t cmd,
	output cfm_pkg::status_t status,
	input  logic [cfm_pkg::FIELD_W-1:0] ref_time,
	input  logic [cfm_pkg::FIELD_W-1:0] cycle_count,
	input  logic cfg_wr,
	input  logic [cfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cfm_pkg::FIELD_W-1:0] cfg_data,
	input  logic out_stall,
	output logic out_valid,
	output logic [cfm_pkg::FIELD_W-1:0] cpu_freq_hz,
	output logic saturated
);

	localparam int TW = TIME_WIDTH;
	localparam int CW = CYCLE_WIDTH;
	localparam int FW = cfm_pkg::FIELD_W;
	localparam int QW = (CW > FW) ? CW : FW;
	localparam int NSTEP = (CW > 2 * FW) ? CW : 2 * FW;
	localparam int CNT_W = $clog2(NSTEP);
	localparam int FBIT_W = $clog2(FW);

	logic [FW-1:0] ref_freq_q;
	logic [cfm_pkg::TICK_W-1:0] tick_count_q;
	logic [TW-1:0] first_ref_q;
	logic [TW-1:0] edge_ref_q;
	logic [CW-1:0] edge_cyc_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic [FW-1:0] out_freq_q;
	logic out_sat_q;

	logic [TW-1:0] dm_q;
	logic [CW-1:0] dvd_q;
	logic [TW-1:0] rem_q;
	logic [TW-1:0] r_q;
	logic [FW-1:0] acc_q;
	logic sticky_q;

	logic [TW-1:0] rt_w;
	logic [CW-1:0] cc_w;
	logic [TW-1:0] dm_w;
	logic [CW-1:0] dc_w;
	logic [cfm_pkg::TICK_W-1:0] ticks_w;
	logic shift_in;
	logic add_phase;
	logic [TW:0] s_dbl;
	logic [TW:0] s_add;
	logic [TW:0] s_w;
	logic ge;
	logic [TW:0] s_red;
	logic fbit;
	logic [FW:0] dbl_sum;
	logic [QW:0] add_sum;

	assign rt_w = TW'(ref_time);
	assign cc_w = CW'(cycle_count);
	assign dm_w = rt_w - edge_ref_q;
	assign dc_w = cc_w - edge_cyc_q;
	assign ticks_w = (tick_count_q == '0) ? cfm_pkg::TICK_W'(1) : tick_count_q;

	assign status.ref_changed = (rt_w != first_ref_q);
	assign status.window_done = (dm_w >= TW'(ticks_w));
	assign status.step_last = (cnt_q == '0);
	assign status.out_free = !out_valid_q || !out_stall;

	// One conditional subtract serves both the long division and the scaling.
	assign add_phase = cmd.frac_step && !cnt_q[0];
	assign shift_in = cmd.div_step ? dvd_q[CW-1] : 1'b0;
	assign s_dbl = {rem_q, shift_in};
	assign s_add = {1'b0, rem_q} + {1'b0, r_q};
	assign s_w = add_phase ? s_add : s_dbl;
	assign ge = (s_w >= {1'b0, dm_q});
	assign s_red = ge ? (s_w - {1'b0, dm_q}) : s_w;
	assign fbit = ref_freq_q[cnt_q[FBIT_W:1]];
	assign dbl_sum = {acc_q, 1'b0} + (FW+1)'(ge);
	assign add_sum = (QW+1)'(acc_q) + (QW+1)'(dvd_q) + (QW+1)'(ge);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_freq_q <= cfm_pkg::REF_FREQ_RESET;
			tick_count_q <= cfm_pkg::TICK_COUNT_RESET;
			first_ref_q <= '0;
			edge_ref_q <= '0;
			edge_cyc_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					cfm_pkg::REG_REF_FREQ: ref_freq_q <= cfg_data;
					cfm_pkg::REG_TICK_COUNT: tick_count_q <= cfg_data[cfm_pkg::TICK_W-1:0];
					default: ;
				endcase
			end
			if (cmd.capture_first) begin
				first_ref_q <= rt_w;
			end
			if (cmd.capture_edge) begin
				edge_ref_q <= rt_w;
				edge_cyc_q <= cc_w;
			end
			if (cmd.load_div) begin
				cnt_q <= CNT_W'(CW - 1);
			end else if (cmd.div_step && cnt_q == '0) begin
				cnt_q <= CNT_W'(2 * FW - 1);
			end else if (cmd.div_step || cmd.frac_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			dm_q <= dm_w;
			dvd_q <= dc_w;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[CW-2:0], ge};
			if (cnt_q == '0) begin
				r_q <= s_red[TW-1:0];
				rem_q <= '0;
				acc_q <= '0;
				sticky_q <= 1'b0;
			end else begin
				rem_q <= s_red[TW-1:0];
			end
		end else if (cmd.frac_step) begin
			if (!add_phase) begin
				rem_q <= s_red[TW-1:0];
				acc_q <= dbl_sum[FW-1:0];
				sticky_q <= sticky_q | dbl_sum[FW];
			end else if (fbit) begin
				rem_q <= s_red[TW-1:0];
				acc_q <= add_sum[FW-1:0];
				sticky_q <= sticky_q | (|add_sum[QW:FW]);
			end
		end
		if (cmd.load_out) begin
			out_freq_q <= sticky_q ? '1 : acc_q;
			out_sat_q <= sticky_q;
		end
	end

	assign out_valid = out_valid_q;
	assign cpu_freq_hz = out_freq_q;
	assign saturated = out_sat_q;

endmodule

// ----- rtl/cfm_ctrl.sv -----
// Controller state machine of the clock frequency meter.
module cfm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic start_req,
	input  cfm_pkg::status_t status,
	output cfm_pkg::cmd_t cmd,
	output logic in_stall
);

	cfm_pkg::state_t state_q;
	cfm_pkg::state_t state_nxt;
	logic take;

	assign in_stall = (state_q == cfm_pkg::S_DIV) || (state_q == cfm_pkg::S_FRAC)
		|| (state_q == cfm_pkg::S_FINISH);
	assign take = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			cfm_pkg::S_IDLE: begin
				if (take && start_req) begin
					cmd.capture_first = 1'b1;
					state_nxt = cfm_pkg::S_WAIT_EDGE;
				end
			end
			cfm_pkg::S_WAIT_EDGE: begin
				if (take && start_req) begin
					cmd.capture_first = 1'b1;
				end else if (take && status.ref_changed) begin
					cmd.capture_edge = 1'b1;
					state_nxt = cfm_pkg::S_MEASURE;
				end
			end
			cfm_pkg::S_MEASURE: begin
				if (take && start_req) begin
					cmd.capture_first = 1'b1;
					state_nxt = cfm_pkg::S_WAIT_EDGE;
				end else if (take && status.window_done) begin
					cmd.load_div = 1'b1;
					state_nxt = cfm_pkg::S_DIV;
				end
			end
			cfm_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.step_last) begin
					state_nxt = cfm_pkg::S_FRAC;
				end
			end
			cfm_pkg::S_FRAC: begin
				cmd.frac_step = 1'b1;
				if (status.step_last) begin
					state_nxt = cfm_pkg::S_FINISH;
				end
			end
			cfm_pkg::S_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = cfm_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = cfm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfm_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/cfm_checker.sv -----
// Port-level checker of the clock frequency meter and its bind to the top level.
`include "cpu_clock_frequency_meter_macros.svh"

module cfm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [cfm_pkg::FIELD_W-1:0] cpu_freq_hz,
	input logic saturated
);

	// A stalled result beat stays offered.
	`CFM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")

	// A stalled result beat keeps its payload.
	`CFM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(cpu_freq_hz) && $stable(saturated), "stalled result beat changed")

	// A saturated result reads as all ones.
	`CFM_ASSERT_NOW(a_sat_value, out_valid && saturated, cpu_freq_hz == '1, "saturated result is not all ones")

	// A new result only follows the computation, during which the input is stalled.
	`CFM_ASSERT_NOW(a_result_after_calc, $rose(out_valid), $past(in_stall), "result appeared without a computation")

endmodule

bind cpu_clock_frequency_meter cfm_checker u_cfm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.cpu_freq_hz(cpu_freq_hz),
	.saturated(saturated)
);
